@@ hw/rtl/sims_pkg.sv @@
// ----------------------------------------------------------------------------
// sims_pkg
// Shared types and constants for the sorted interval mask sweep block.
// ----------------------------------------------------------------------------
package sims_pkg;

    // fixed field widths
    localparam int CHROM_W  = 5;
    localparam int POS_W    = 32;
    localparam int SAMPLE_W = 3;
    localparam int MASK_W   = 8;
    localparam int ACT_W    = 4;

    localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

    // input item
    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample;
        logic [CHROM_W-1:0]  chrom;
        logic [POS_W-1:0]    interval_start;
        logic [POS_W-1:0]    interval_stop;
        logic [POS_W-1:0]    query_pos;
    } t_in;

    // result item
    typedef struct packed {
        logic [MASK_W-1:0] hit_mask;
        logic              load_dropped;
    } t_out;

    typedef logic [MASK_W-1:0] t_mask;

    // command kinds
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd_kind;

    // classified command handed from front to back
    typedef struct packed {
        t_cmd_kind           kind;
        logic                bad_sample;
        logic [SAMPLE_W-1:0] sample;
        logic [CHROM_W-1:0]  chrom;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    stop;
        logic [POS_W-1:0]    query_pos;
    } t_cmd;

    // interval store entry
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   stop;
    } t_entry;

    // back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_PTR_RD = 3'd1,
        BK_PTR_EV = 3'd2,
        BK_DAT_RD = 3'd3,
        BK_DAT_EV = 3'd4
    } t_bk_state;

    // back-end status toward front and top
    typedef struct packed {
        logic pop;
        logic busy;
    } t_bk_sts;

endpackage

@@ hw/rtl/sims_front.sv @@
// ----------------------------------------------------------------------------
// sims_front
// Accepts input items, classifies them into commands and holds them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module sims_front #(
    parameter int NUM_SAMPLES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sims_pkg::t_in     i_in_data,
    output logic              o_in_stall,
    output logic              o_cmd_valid,
    output sims_pkg::t_cmd    o_cmd,
    input  sims_pkg::t_bk_sts i_bk_sts
);
    import sims_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // classify the incoming item
    always_comb begin
        w_cmd = '0;
        case (i_in_data.req_type)
            1'b1:    w_cmd.kind = CMD_QUERY;
            default: w_cmd.kind = CMD_LOAD;
        endcase
        w_cmd.bad_sample = (w_cmd.kind == CMD_LOAD) &&
                           (32'(i_in_data.sample) >= 32'(NUM_SAMPLES));
        w_cmd.sample     = i_in_data.sample;
        w_cmd.chrom      = i_in_data.chrom;
        w_cmd.start      = i_in_data.interval_start;
        w_cmd.stop       = i_in_data.interval_stop;
        w_cmd.query_pos  = i_in_data.query_pos;
    end

    // queue handshake
    assign o_in_stall  = (r_count == 2'(QDEPTH));
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_bk_sts.pop;

    // pointer and count update
    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

@@ hw/rtl/sims_back.sv @@
// ----------------------------------------------------------------------------
// sims_back
// Executes commands: appends loads to per-sample interval queues and sweeps
// the queue heads of every active sample for each query.
// ----------------------------------------------------------------------------
module sims_back #(
    parameter int NUM_SAMPLES = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sims_pkg::ACT_W-1:0]  i_active,
    input  logic                        i_cmd_valid,
    input  sims_pkg::t_cmd              i_cmd,
    output sims_pkg::t_bk_sts           o_bk_sts,
    output logic                        o_out_valid,
    output sims_pkg::t_out              o_out_data,
    input  logic                        i_out_stall
);
    import sims_pkg::*;

    localparam int SW  = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NW0 = $clog2(NUM_SAMPLES + 1);
    localparam int NW  = (NW0 > ACT_W) ? NW0 : ACT_W;
    localparam int AW  = SW + QW;
    localparam int DDEPTH = 1 << AW;

    typedef struct packed {
        logic [QW-1:0] head;
        logic [QW-1:0] tail;
        logic [FW-1:0] fill;
    } t_ptr;

    // sequencer and working registers
    t_bk_state     r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [SW-1:0] r_cur, n_cur;
    logic [NW-1:0] r_nsmp, n_nsmp;
    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    t_mask         r_mask, n_mask;
    logic          r_out_vld, n_out_vld;
    t_out          r_out, n_out;

    // memories
    t_entry           r_dat_mem [DDEPTH];
    t_entry           r_dat_q;
    t_ptr             r_ptr_mem [NUM_SAMPLES];
    t_ptr             r_ptr_q;
    logic             r_ptr_v;
    logic [NUM_SAMPLES-1:0] r_ptr_vld;

    // combinational helpers
    logic          w_start;
    logic [NW-1:0] w_nsmp_in;
    logic          w_last;
    t_ptr          w_ptr;
    logic          w_later;
    logic          w_pop_head;
    logic          w_hit;
    logic [QW-1:0] w_head_nx;
    logic [FW-1:0] w_fill_dn;
    logic          w_dat_we;
    t_entry        w_dat_wdata;
    logic          w_ptr_we;
    t_ptr          w_ptr_wdata;
    logic          w_prod;
    t_out          w_prod_data;

    function automatic logic [QW-1:0] f_next_slot(input logic [QW-1:0] idx);
        logic [QW-1:0] res;
        res = (idx == QW'(QUEUE_DEPTH - 1)) ? '0 : idx + QW'(1);
        return res;
    endfunction

    // start a command when the result slot is free or draining
    assign w_start   = (r_state == BK_IDLE) && i_cmd_valid &&
                       (!r_out_vld || !i_out_stall);
    assign w_nsmp_in = (32'(i_active) > 32'(NUM_SAMPLES)) ? NW'(NUM_SAMPLES)
                                                            : NW'(i_active);
    assign w_last    = ((NW'(r_cur) + NW'(1)) == r_nsmp);
    assign w_ptr     = r_ptr_v ? r_ptr_q : '0;

    // head interval compare
    assign w_later    = (r_dat_q.chrom > r_cmd.chrom);
    assign w_pop_head = !w_later && ((r_dat_q.chrom < r_cmd.chrom) ||
                                     (r_cmd.query_pos > r_dat_q.stop));
    assign w_hit      = !w_later && !w_pop_head &&
                        (r_cmd.query_pos >= r_dat_q.start);
    assign w_head_nx  = f_next_slot(r_head);
    assign w_fill_dn  = r_fill - FW'(1);

    assign o_bk_sts.pop  = w_start;
    assign o_bk_sts.busy = (r_state != BK_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_out_data    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_start) begin
                    if (i_cmd.kind == CMD_QUERY) begin
                        n_state = (w_nsmp_in == '0) ? BK_IDLE : BK_PTR_RD;
                    end else begin
                        n_state = i_cmd.bad_sample ? BK_IDLE : BK_PTR_RD;
                    end
                end
            end
            BK_PTR_RD: n_state = BK_PTR_EV;
            BK_PTR_EV: begin
                if (r_cmd.kind == CMD_LOAD) begin
                    n_state = BK_IDLE;
                end else if (w_ptr.fill == '0) begin
                    n_state = w_last ? BK_IDLE : BK_PTR_RD;
                end else begin
                    n_state = BK_DAT_RD;
                end
            end
            BK_DAT_RD: n_state = BK_DAT_EV;
            BK_DAT_EV: begin
                if (w_pop_head && (w_fill_dn != '0)) begin
                    n_state = BK_DAT_RD;
                end else begin
                    n_state = w_last ? BK_IDLE : BK_PTR_RD;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd       = r_cmd;
        n_cur       = r_cur;
        n_nsmp      = r_nsmp;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_mask      = r_mask;
        w_dat_we    = 1'b0;
        w_dat_wdata = '0;
        w_ptr_we    = 1'b0;
        w_ptr_wdata = '0;
        w_prod      = 1'b0;
        w_prod_data = '0;
        case (r_state)
            BK_IDLE: begin
                if (w_start) begin
                    n_cmd  = i_cmd;
                    n_mask = '0;
                    n_nsmp = w_nsmp_in;
                    if (i_cmd.kind == CMD_QUERY) begin
                        n_cur = '0;
                        if (w_nsmp_in == '0) begin
                            w_prod = 1'b1;
                        end
                    end else begin
                        n_cur = SW'(i_cmd.sample);
                        if (i_cmd.bad_sample) begin
                            w_prod                   = 1'b1;
                            w_prod_data.load_dropped = 1'b1;
                        end
                    end
                end
            end
            BK_PTR_EV: begin
                n_head = w_ptr.head;
                n_tail = w_ptr.tail;
                n_fill = w_ptr.fill;
                if (r_cmd.kind == CMD_LOAD) begin
                    w_prod = 1'b1;
                    if (w_ptr.fill == FW'(QUEUE_DEPTH)) begin
                        w_prod_data.load_dropped = 1'b1;
                    end else begin
                        w_dat_we          = 1'b1;
                        w_dat_wdata.chrom = r_cmd.chrom;
                        w_dat_wdata.start = r_cmd.start;
                        w_dat_wdata.stop  = r_cmd.stop;
                        w_ptr_we          = 1'b1;
                        w_ptr_wdata.head  = w_ptr.head;
                        w_ptr_wdata.tail  = f_next_slot(w_ptr.tail);
                        w_ptr_wdata.fill  = w_ptr.fill + FW'(1);
                    end
                end else if (w_ptr.fill == '0) begin
                    // empty queue: no hit, move on
                    if (w_last) begin
                        w_prod               = 1'b1;
                        w_prod_data.hit_mask = r_mask;
                    end else begin
                        n_cur = r_cur + SW'(1);
                    end
                end
            end
            BK_DAT_EV: begin
                if (w_pop_head) begin
                    n_head = w_head_nx;
                    n_fill = w_fill_dn;
                end
                if (!(w_pop_head && (w_fill_dn != '0))) begin
                    // sample finished: write pointers back, record hit
                    w_ptr_we         = 1'b1;
                    w_ptr_wdata.head = w_pop_head ? w_head_nx : r_head;
                    w_ptr_wdata.tail = r_tail;
                    w_ptr_wdata.fill = w_pop_head ? w_fill_dn : r_fill;
                    n_mask           = r_mask | (t_mask'(w_hit) << r_cur);
                    if (w_last) begin
                        w_prod               = 1'b1;
                        w_prod_data.hit_mask = n_mask;
                    end else begin
                        n_cur = r_cur + SW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_comb begin
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        if (w_prod) begin
            n_out_vld = 1'b1;
            n_out     = w_prod_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_out_vld <= 1'b0;
            r_ptr_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (w_ptr_we) begin
                r_ptr_vld[r_cur] <= 1'b1;
            end
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_cur  <= n_cur;
        r_nsmp <= n_nsmp;
        r_head <= n_head;
        r_tail <= n_tail;
        r_fill <= n_fill;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    // pointer memory, one entry per sample
    always_ff @(posedge i_clk) begin
        if (w_ptr_we) begin
            r_ptr_mem[r_cur] <= w_ptr_wdata;
        end
        if (r_state == BK_PTR_RD) begin
            r_ptr_q <= r_ptr_mem[r_cur];
            r_ptr_v <= r_ptr_vld[r_cur];
        end
    end

    // interval memory, addressed by sample and slot
    always_ff @(posedge i_clk) begin
        if (w_dat_we) begin
            r_dat_mem[{r_cur, w_ptr.tail}] <= w_dat_wdata;
        end
        if (r_state == BK_DAT_RD) begin
            r_dat_q <= r_dat_mem[{r_cur, r_head}];
        end
    end

endmodule

@@ hw/rtl/sorted_interval_mask_sweep_top.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_mask_sweep_top
// Per-sample sorted interval queues swept by an ascending stream of query
// positions; each query returns a per-sample hit mask.
// ----------------------------------------------------------------------------
//  channel  signals                               direction  transfer when
//  in       i_in_valid, i_in_data, o_in_stall     to block   valid && !stall
//  out      o_out_valid, o_out_data, i_out_stall  from block valid && !stall
//  cfg      i_cfg_wen, i_cfg_wdata                to block   wen
//
// one item in the sweep engine at a time; a two-entry command queue keeps
// taking items meanwhile. a load reads the sample's pointer entry, then appends
// if there is room; a query reads each active sample's pointer entry and, unless
// the queue is empty, its head interval, again per popped head; reads are registered.
// reset is synchronous and clears the queues; the interval store is not cleared.
// a stalled result keeps the engine from starting the next command.
// ----------------------------------------------------------------------------
module sorted_interval_mask_sweep_top #(
    parameter int NUM_SAMPLES = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  sims_pkg::t_in              i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output sims_pkg::t_out             o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_wen,
    input  logic [sims_pkg::ACT_W-1:0] i_cfg_wdata
);
    import sims_pkg::*;

    logic [ACT_W-1:0] r_active;
    logic             w_cmd_vld;
    t_cmd             w_cmd;
    t_bk_sts          w_bk_sts;

    // active sample count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACT_RESET;
        end else if (i_cfg_wen) begin
            r_active <= i_cfg_wdata;
        end
    end

    // front: accept and classify
    sims_front #(
        .NUM_SAMPLES(NUM_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_cmd_valid(w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_bk_sts   (w_bk_sts)
    );

    // back: queue update and sweep
    sims_back #(
        .NUM_SAMPLES(NUM_SAMPLES),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_active   (r_active),
        .i_cmd_valid(w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_bk_sts   (w_bk_sts),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    // engine only takes a command that is present
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_sts.pop |-> w_cmd_vld)
        else $error("command taken from empty queue");

    // no new command while the engine is working
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_sts.busy |-> !w_bk_sts.pop)
        else $error("command taken while engine busy");

    // a command starts only when the result slot can take its result
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_sts.pop |-> (!o_out_valid || !i_out_stall))
        else $error("command started with result slot blocked");

endmodule
